FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CSIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define CSIM_NEVER(lbl, cond, msg) \
    `CSIM_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/csim_pkg.sv
`default_nettype none

package csim_pkg;

    localparam int ACC_W       = 48;
    localparam int HALF_W      = 24;
    localparam int PROD_W      = 96;
    localparam int MUL_STEPS   = 8;
    localparam int DIV_STEPS   = 30;
    localparam int SQRT_STEPS  = 15;
    localparam int ROOT_W      = 15;
    localparam int SQ_REM_W    = 19;
    localparam int MAG_W       = 15;
    localparam int SIM_W       = 16;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ACC_W:0]   ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0]        ONE_Q14 = 15'd16384;
    localparam logic signed [SIM_W-1:0] SIM_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic signed [ACC_W-1:0] norm_a;
        logic signed [ACC_W-1:0] norm_b;
    } sums_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
        logic signed [ACC_W:0] r;
        begin
            if (s > ACC_MAX)
            begin
                r = ACC_MAX;
            end
            else if (s < -ACC_MAX)
            begin
                r = -ACC_MAX;
            end
            else
            begin
                r = s;
            end
            return r[ACC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/csim_front.sv
`default_nettype none
`include "assert_macros.svh"

module csim_front #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         last_elem,
    output logic                         q_push,
    output csim_pkg::sums_t              q_data,
    input  logic                         q_full
);

    localparam int ACC_W  = csim_pkg::ACC_W;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int EXT_W  = ACC_W + 1 - PROD_W;

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] prod_ab_reg;
    logic signed [PROD_W-1:0] prod_aa_reg;
    logic signed [PROD_W-1:0] prod_bb_reg;
    logic signed [ACC_W-1:0]  dot_reg;
    logic signed [ACC_W-1:0]  norm_a_reg;
    logic signed [ACC_W-1:0]  norm_b_reg;

    logic                     accept;
    logic                     s1_block;
    logic                     s1_adv;
    logic signed [ACC_W-1:0]  dot_sum;
    logic signed [ACC_W-1:0]  norm_a_sum;
    logic signed [ACC_W-1:0]  norm_b_sum;

    // a last pair waits in stage one until the queue has room
    assign s1_block = s1_valid_reg & s1_last_reg & q_full;
    assign s1_adv   = s1_valid_reg & ~s1_block;
    assign in_stall = s1_block;
    assign accept   = in_valid & ~in_stall;

    assign dot_sum = csim_pkg::sat_acc($signed({dot_reg[ACC_W-1], dot_reg})
        + $signed({{EXT_W{prod_ab_reg[PROD_W-1]}}, prod_ab_reg}));
    assign norm_a_sum = csim_pkg::sat_acc($signed({norm_a_reg[ACC_W-1], norm_a_reg})
        + $signed({{EXT_W{prod_aa_reg[PROD_W-1]}}, prod_aa_reg}));
    assign norm_b_sum = csim_pkg::sat_acc($signed({norm_b_reg[ACC_W-1], norm_b_reg})
        + $signed({{EXT_W{prod_bb_reg[PROD_W-1]}}, prod_bb_reg}));

    assign q_push        = s1_adv & s1_last_reg;
    assign q_data.dot    = dot_sum;
    assign q_data.norm_a = norm_a_sum;
    assign q_data.norm_b = norm_b_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            dot_reg      <= '0;
            norm_a_reg   <= '0;
            norm_b_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                if (s1_last_reg)
                begin
                    dot_reg    <= '0;
                    norm_a_reg <= '0;
                    norm_b_reg <= '0;
                end
                else
                begin
                    dot_reg    <= dot_sum;
                    norm_a_reg <= norm_a_sum;
                    norm_b_reg <= norm_b_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last_elem;
            prod_ab_reg <= elem_a * elem_b;
            prod_aa_reg <= elem_a * elem_a;
            prod_bb_reg <= elem_b * elem_b;
        end
    end

    `CSIM_ASSERT(a_clear_after_last, (s1_adv && s1_last_reg) |=> (dot_reg == '0 && norm_a_reg == '0 && norm_b_reg == '0), "accumulators not cleared after last pair")

endmodule

`default_nettype wire

FILE: src/csim_queue.sv
`default_nettype none
`include "assert_macros.svh"

module csim_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csim_pkg::sums_t push_data,
    output logic            full,
    output logic            q_valid,
    input  logic            pop,
    output csim_pkg::sums_t head
);

    localparam int DEPTH = csim_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csim_pkg::sums_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CSIM_NEVER(a_no_overflow, push && full, "push into full queue")
    `CSIM_NEVER(a_no_underflow, pop && !q_valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: src/csim_back.sv
`default_nettype none
`include "assert_macros.svh"

module csim_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  csim_pkg::sums_t                     head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [csim_pkg::SIM_W-1:0]   similarity,
    output logic                                zero_norm
);

    localparam int ACC_W    = csim_pkg::ACC_W;
    localparam int HALF_W   = csim_pkg::HALF_W;
    localparam int PROD_W   = csim_pkg::PROD_W;
    localparam int DIV_W    = csim_pkg::DIV_STEPS;
    localparam int ROOT_W   = csim_pkg::ROOT_W;
    localparam int SQ_REM_W = csim_pkg::SQ_REM_W;
    localparam int MAG_W    = csim_pkg::MAG_W;
    localparam int SIM_W    = csim_pkg::SIM_W;
    localparam int CNT_W    = csim_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]              state_reg,  state_next;
    logic [CNT_W-1:0]        cnt_reg,    cnt_next;
    logic                    neg_reg,    neg_next;
    logic                    zero_reg,   zero_next;
    logic [ACC_W-1:0]        mag_reg,    mag_next;
    logic [ACC_W-1:0]        na_reg,     na_next;
    logic [ACC_W-1:0]        nb_reg,     nb_next;
    logic [PROD_W-1:0]       d2_reg,     d2_next;
    logic [PROD_W-1:0]       p_reg,      p_next;
    logic [PROD_W-1:0]       rem_reg,    rem_next;
    logic [DIV_W-1:0]        quo_reg,    quo_next;
    logic [SQ_REM_W-1:0]     sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]       root_reg,   root_next;
    logic [MAG_W-1:0]        k_reg,      k_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SIM_W-1:0] similarity_reg;
    logic                    zero_norm_reg;

    logic                    load_out;
    logic [ACC_W-1:0]        op_x;
    logic [ACC_W-1:0]        op_y;
    logic [HALF_W-1:0]       hx;
    logic [HALF_W-1:0]       hy;
    logic [2*HALF_W-1:0]     pp;
    logic [1:0]              pp_pos;
    logic [PROD_W-1:0]       pp_wide;
    logic [PROD_W:0]         div_sh;
    logic                    div_ge;
    logic [PROD_W:0]         div_diff;
    logic [SQ_REM_W-1:0]     sq_in;
    logic [SQ_REM_W-1:0]     sq_trial;
    logic                    sq_ge;
    logic [ROOT_W-1:0]       root_new;
    logic [ROOT_W:0]         root_p1;
    logic signed [SIM_W-1:0] mag_s;
    logic signed [SIM_W-1:0] sim_val;

    // shared 24x24 multiplier, four partial products per 96-bit product
    assign op_x    = cnt_reg[2] ? na_reg : mag_reg;
    assign op_y    = cnt_reg[2] ? nb_reg : mag_reg;
    assign hx      = cnt_reg[1] ? op_x[ACC_W-1:HALF_W] : op_x[HALF_W-1:0];
    assign hy      = cnt_reg[0] ? op_y[ACC_W-1:HALF_W] : op_y[HALF_W-1:0];
    assign pp      = hx * hy;
    assign pp_pos  = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
    assign pp_wide = PROD_W'(pp) << (pp_pos * HALF_W);

    // restoring division, dot squared over norm product, zeros shifted in
    assign div_sh   = {rem_reg, 1'b0};
    assign div_ge   = (div_sh >= {1'b0, p_reg});
    assign div_diff = div_sh - {1'b0, p_reg};

    // integer square root, two radicand bits per step
    assign sq_in    = {sq_rem_reg[SQ_REM_W-3:0], quo_reg[DIV_W-1:DIV_W-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_in >= sq_trial);
    assign root_new = {root_reg[ROOT_W-2:0], sq_ge};
    assign root_p1  = {1'b0, root_new} + 1'b1;

    assign mag_s   = $signed({1'b0, k_reg});
    assign sim_val = neg_reg ? -mag_s : mag_s;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        mag_next    = mag_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        d2_next     = d2_reg;
        p_next      = p_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        sq_rem_next = sq_rem_reg;
        root_next   = root_reg;
        k_next      = k_reg;
        pop         = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    neg_next  = head.dot[ACC_W-1];
                    zero_next = (head.norm_a == '0) || (head.norm_b == '0);
                    mag_next  = head.dot[ACC_W-1] ? ACC_W'(-head.dot) : ACC_W'(head.dot);
                    na_next   = ACC_W'(head.norm_a);
                    nb_next   = ACC_W'(head.norm_b);
                    d2_next   = '0;
                    p_next    = '0;
                    cnt_next  = '0;
                    if ((head.norm_a == '0) || (head.norm_b == '0))
                    begin
                        k_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (!cnt_reg[2])
                begin
                    d2_next = d2_reg + pp_wide;
                end
                else
                begin
                    p_next = p_reg + pp_wide;
                end
                if (cnt_reg == CNT_W'(csim_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_CMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CMP:
            begin
                // quotient at or above 2^30 saturates to one
                if (d2_reg >= p_reg)
                begin
                    k_next     = csim_pkg::ONE_Q14;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = d2_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? div_diff[PROD_W-1:0] : div_sh[PROD_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], div_ge};
                if (cnt_reg == CNT_W'(csim_pkg::DIV_STEPS - 1))
                begin
                    cnt_next    = '0;
                    sq_rem_next = '0;
                    root_next   = '0;
                    state_next  = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                sq_rem_next = sq_ge ? sq_in - sq_trial : sq_in;
                root_next   = root_new;
                quo_next    = {quo_reg[DIV_W-3:0], 2'b00};
                if (cnt_reg == CNT_W'(csim_pkg::SQRT_STEPS - 1))
                begin
                    // the root plus one, halved, gives the rounded result
                    k_next     = root_p1[ROOT_W:1];
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        mag_reg    <= mag_next;
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        d2_reg     <= d2_next;
        p_reg      <= p_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sq_rem_reg <= sq_rem_next;
        root_reg   <= root_next;
        k_reg      <= k_next;
        if (load_out)
        begin
            similarity_reg <= sim_val;
            zero_norm_reg  <= zero_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign similarity = similarity_reg;
    assign zero_norm  = zero_norm_reg;

    `CSIM_NEVER(a_sim_range, out_valid_reg && (similarity_reg > csim_pkg::SIM_ONE || similarity_reg < -csim_pkg::SIM_ONE), "similarity outside plus or minus one")
    `CSIM_ASSERT(a_zero_norm_result, (out_valid_reg && zero_norm_reg) |-> (similarity_reg == '0), "zero norm with nonzero similarity")

endmodule

`default_nettype wire

FILE: src/cosine_similarity_stream_unit.sv
`default_nettype none

// Streaming cosine similarity of two signed Q4.12 vectors given as element pairs, one pair
// per transaction, with last_elem on the final pair. The front end takes one pair every
// cycle unless in_stall is high, squares and multiplies it and adds into three saturating
// 48-bit accumulators; a last pair hands the three sums to a two-entry queue and clears
// them. The back end works on one vector at a time: a shared 24x24 multiplier for the two
// 96-bit products, one compare, thirty restoring division steps and fifteen square root
// steps, then the output register; a zero norm skips straight to the output register.
// Pairs stream at one per cycle while the back end drains the queue in time; otherwise
// they are bounded by the back end, and in_stall rises only while a last pair finds the
// queue full. similarity is signed Q1.14, rounded to nearest with ties away from zero and
// saturated to plus or minus one; zero_norm flags a vector with zero norm, with
// similarity then zero.
module cosine_similarity_stream_unit #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ELEM_WIDTH-1:0]        elem_a,
    input  logic signed [ELEM_WIDTH-1:0]        elem_b,
    input  logic                                last_elem,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [csim_pkg::SIM_W-1:0]   similarity,
    output logic                                zero_norm
);

    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    csim_pkg::sums_t q_data;
    csim_pkg::sums_t q_head;

    csim_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last_elem (last_elem),
        .q_push    (q_push),
        .q_data    (q_data),
        .q_full    (q_full)
    );

    csim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (q_pop),
        .head      (q_head)
    );

    csim_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

`default_nettype wire
